// ===== src/cndp_pkg.sv =====
package cndp_pkg;

	// Default sizing of the occupancy table
	localparam int MIN_COUPONS_D  = 1;
	localparam int MAX_COUPONS_D  = 16;
	localparam int MAX_DRAWS_D    = 64;
	localparam int MAX_DISTINCT_D = 16;

	// Q2.30 fixed point
	localparam int          VAL_W = 32;
	localparam int          PROB_W = 31;
	localparam logic [31:0] Q_ONE = 32'h4000_0000;

	// Input item fields
	localparam int CNT_IN_W  = 5;
	localparam int DRAW_IN_W = 6;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 32;

	// Item kinds carried on tuser
	localparam logic MODE_BUILD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== src/coupon_new_draw_probability_top.sv =====
// Query: sums up to min(n, N, MAX_DISTINCT + 1) - 1 terms, one PW-bit serial division each,
//   PW = 32 + clog2(MAX_COUPONS + 1) (37 with defaults).
// Out-of-range queries, n = 1 and N = 1 skip the sum and go straight to S_DONE.
// Build: sweeps each (N, n, k) with k <= min(n, N, MAX_DISTINCT), up to two divisions per entry.
// The divider is bit-serial and the table has one read and one write port; one item at a time.
// Reset clears control and the built flag; the table holds garbage until the first build.
module coupon_new_draw_probability_top #(
	parameter int MIN_COUPONS  = cndp_pkg::MIN_COUPONS_D,
	parameter int MAX_COUPONS  = cndp_pkg::MAX_COUPONS_D,
	parameter int MAX_DRAWS    = cndp_pkg::MAX_DRAWS_D,
	parameter int MAX_DISTINCT = cndp_pkg::MAX_DISTINCT_D
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [4:0] coupon_count, [10:5] draw_index, rest zero
	input  logic [cndp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] mode
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [30:0] probability, rest zero
	output logic [cndp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// [0] range_error
	output logic                             m_axis_tuser
);
	import cndp_pkg::*;

	localparam int N_SETS = MAX_COUPONS - MIN_COUPONS + 1;
	localparam int DEPTH  = N_SETS * MAX_DRAWS * MAX_DISTINCT;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW     = $clog2(MAX_COUPONS + 1);
	localparam int RW     = MW + 1;
	localparam int PW     = VAL_W + MW;
	localparam int BW     = $clog2(PW);
	localparam int DW     = $clog2(MAX_DRAWS + 1);
	localparam int KW     = $clog2(MAX_DISTINCT + 2);
	localparam int AC     = VAL_W + KW;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_INIT  = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_LD    = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_ACC   = 8'b0010_0000,
		S_WR    = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic              qry_q, term_b_q, built_q;
	logic [MW-1:0]     cnt_q;
	logic [DW-1:0]     draw_q;
	logic [KW-1:0]     k_q;
	logic [MW-1:0]     mul_q;
	logic [PW-1:0]     dq_q;
	logic [RW-1:0]     rem_q;
	logic [BW-1:0]     bit_q;
	logic [AC-1:0]     acc_q;
	logic [PROB_W-1:0] res_prob_q;
	logic              res_err_q;
	logic              m_valid_q;
	logic [PROB_W-1:0] m_prob_q;
	logic              m_err_q;

	logic [VAL_W-1:0]  mem [DEPTH];
	logic [VAL_W-1:0]  rdata_q;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [VAL_W-1:0]  wdata;

	logic [CNT_IN_W-1:0]  in_cnt;
	logic [DRAW_IN_W-1:0] in_draw;
	logic                 in_bad;
	logic [RW-1:0]        rs;
	logic                 ge;
	logic [KW-1:0]        k_nx;
	logic                 k_last;
	logic                 q_more;
	logic [AC-1:0]        acc_nx;
	logic                 skip_a;

	function automatic logic [AW-1:0] slot(input int c, input int d, input int k);
		int a;
		a = ((c - MIN_COUPONS) * MAX_DRAWS + (d - 1)) * MAX_DISTINCT + (k - 1);
		return AW'(a);
	endfunction

	assign in_cnt  = s_axis_tdata[CNT_IN_W-1:0];
	assign in_draw = s_axis_tdata[CNT_IN_W +: DRAW_IN_W];
	assign in_bad  = !built_q || (int'(in_cnt) < MIN_COUPONS) || (int'(in_cnt) > MAX_COUPONS)
		|| (in_draw == '0) || (int'(in_draw) >= MAX_DRAWS);

	assign s_axis_tready = (state_q == S_IDLE);

	// Divider step: one quotient bit a cycle
	assign rs = {rem_q[RW-2:0], dq_q[PW-1]};
	assign ge = (rs >= RW'(cnt_q));

	// Loop bounds
	always_comb begin
		int top, lim;
		top = int'(draw_q);
		if (int'(cnt_q) < top) top = int'(cnt_q);
		if (MAX_DISTINCT < top) top = MAX_DISTINCT;
		lim = int'(draw_q);
		if (int'(cnt_q) < lim) lim = int'(cnt_q);
		k_nx   = k_q + KW'(1);
		k_last = (int'(k_q) >= top);
		q_more = (int'(k_nx) < lim) && (int'(k_nx) <= MAX_DISTINCT);
	end

	assign acc_nx = acc_q + AC'(dq_q[VAL_W-1:0]);
	assign skip_a = !qry_q && !term_b_q && (int'(k_q) == int'(draw_q));

	// Table port
	always_comb begin
		we    = 1'b0;
		waddr = slot(int'(cnt_q), int'(draw_q), int'(k_q));
		wdata = acc_q[VAL_W-1:0];
		if (state_q == S_INIT) begin
			we    = 1'b1;
			waddr = slot(int'(cnt_q), 1, 1);
			wdata = Q_ONE;
		end else if (state_q == S_WR) begin
			we = 1'b1;
		end
		if (term_b_q)
			raddr = slot(int'(cnt_q), int'(draw_q) - 1, int'(k_q) - 1);
		else
			raddr = slot(int'(cnt_q), int'(draw_q) - 1, int'(k_q));
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			built_q    <= 1'b0;
			qry_q      <= 1'b0;
			term_b_q   <= 1'b0;
			cnt_q      <= '0;
			draw_q     <= '0;
			k_q        <= '0;
			mul_q      <= '0;
			dq_q       <= '0;
			rem_q      <= '0;
			bit_q      <= '0;
			acc_q      <= '0;
			res_prob_q <= '0;
			res_err_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					acc_q    <= '0;
					term_b_q <= 1'b0;
					k_q      <= KW'(1);
					if (s_axis_tvalid) begin
						res_prob_q <= '0;
						res_err_q  <= 1'b0;
						if (s_axis_tuser == MODE_BUILD) begin
							qry_q   <= 1'b0;
							cnt_q   <= MW'(MIN_COUPONS);
							state_q <= S_INIT;
						end else begin
							qry_q  <= 1'b1;
							cnt_q  <= MW'(in_cnt);
							draw_q <= DW'(in_draw);
							if (in_bad) begin
								res_err_q <= 1'b1;
								state_q   <= S_DONE;
							end else if (in_draw == DRAW_IN_W'(1)) begin
								res_prob_q <= PROB_W'(Q_ONE);
								state_q    <= S_DONE;
							end else if (in_cnt == CNT_IN_W'(1)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_INIT: begin
					draw_q   <= DW'(2);
					k_q      <= KW'(1);
					acc_q    <= '0;
					term_b_q <= 1'b0;
					state_q  <= S_RD;
				end
				S_RD: begin
					if (skip_a) begin
						term_b_q <= 1'b1;
					end else begin
						if (qry_q)
							mul_q <= cnt_q - MW'(k_q);
						else if (term_b_q)
							mul_q <= cnt_q - MW'(k_q) + MW'(1);
						else
							mul_q <= MW'(k_q);
						state_q <= S_LD;
					end
				end
				S_LD: begin
					dq_q    <= PW'(rdata_q) * PW'(mul_q);
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? (rs - RW'(cnt_q)) : rs;
					dq_q  <= {dq_q[PW-2:0], ge};
					bit_q <= bit_q + BW'(1);
					if (int'(bit_q) == PW - 1)
						state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_nx;
					if (qry_q) begin
						k_q <= k_nx;
						if (q_more) begin
							state_q <= S_RD;
						end else begin
							res_prob_q <= (acc_nx > AC'(Q_ONE)) ? PROB_W'(Q_ONE)
								: acc_nx[PROB_W-1:0];
							state_q <= S_DONE;
						end
					end else if (!term_b_q && (int'(k_q) >= 2)) begin
						term_b_q <= 1'b1;
						state_q  <= S_RD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					acc_q    <= '0;
					term_b_q <= 1'b0;
					if (!k_last) begin
						k_q     <= k_nx;
						state_q <= S_RD;
					end else if (int'(draw_q) < MAX_DRAWS) begin
						draw_q  <= draw_q + DW'(1);
						k_q     <= KW'(1);
						state_q <= S_RD;
					end else if (int'(cnt_q) < MAX_COUPONS) begin
						cnt_q   <= cnt_q + MW'(1);
						state_q <= S_INIT;
					end else begin
						built_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_prob_q  <= '0;
			m_err_q   <= 1'b0;
		end else if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
			m_valid_q <= 1'b1;
			m_prob_q  <= res_prob_q;
			m_err_q   <= res_err_q;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-PROB_W){1'b0}}, m_prob_q};
	assign m_axis_tuser  = m_err_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import cndp_pkg::*;

	localparam int N_MIN      = MIN_COUPONS_D;
	localparam int N_MAX      = MAX_COUPONS_D;
	localparam int DRAWS      = MAX_DRAWS_D;
	localparam int DISTINCT   = MAX_DISTINCT_D;
	localparam int OCC_DEPTH  = (N_MAX - N_MIN + 1) * DRAWS * DISTINCT;
	localparam int RAND_ITEMS = 880;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 3000;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic              err;
	} prob_result_t;

	typedef struct {
		logic         mode;
		logic [4:0]   cnt;
		logic [5:0]   draw;
		logic         fixed;
		prob_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// predictor state
	logic [VAL_W-1:0] occ_prob [OCC_DEPTH];
	logic             table_ready;

	prob_result_t expected_probs [$];
	stim_row_t    stim_rows [$];
	int errors;
	int sent_items, got_items, build_items, query_items, reject_items;
	bit burst;

	coupon_new_draw_probability_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int occ_idx(int n_cpn, int drw, int k);
		return ((n_cpn - N_MIN) * DRAWS + (drw - 1)) * DISTINCT + (k - 1);
	endfunction

	function automatic logic [31:0] mul_div(logic [31:0] v, int mul, int dv);
		logic [63:0] p;
		p = 64'(v) * 64'(mul);
		return 32'(p / 64'(dv));
	endfunction

	// occupancy recurrence over every coupon count
	task automatic build_occupancy();
		int top;
		for (int i = 0; i < OCC_DEPTH; i++)
			occ_prob[i] = '0;
		for (int c = N_MIN; c <= N_MAX; c++) begin
			occ_prob[occ_idx(c, 1, 1)] = Q_ONE;
			for (int d = 2; d <= DRAWS; d++) begin
				top = (d < c) ? d : c;
				if (top > DISTINCT)
					top = DISTINCT;
				occ_prob[occ_idx(c, d, 1)] = mul_div(occ_prob[occ_idx(c, d - 1, 1)], 1, c);
				for (int k = 2; k <= top; k++)
					occ_prob[occ_idx(c, d, k)] =
						mul_div(occ_prob[occ_idx(c, d - 1, k)], k, c) +
						mul_div(occ_prob[occ_idx(c, d - 1, k - 1)], c - k + 1, c);
			end
		end
		table_ready = 1'b1;
	endtask

	function automatic prob_result_t new_draw_prob(logic [4:0] cnt, logic [5:0] drw);
		prob_result_t r;
		logic [63:0] acc;
		int top;
		r = '0;
		acc = '0;
		if (!table_ready || cnt < N_MIN || cnt > N_MAX || drw == 0 || drw >= DRAWS) begin
			r.err = 1'b1;
			return r;
		end
		if (drw == 1) begin
			r.prob = PROB_W'(Q_ONE);
			return r;
		end
		top = (drw < cnt) ? drw : cnt;
		for (int k = 1; k < top && k <= DISTINCT; k++)
			acc += 64'(mul_div(occ_prob[occ_idx(cnt, drw - 1, k)], cnt - k, cnt));
		if (acc > 64'(Q_ONE))
			acc = 64'(Q_ONE);
		r.prob = PROB_W'(acc);
		return r;
	endfunction

	task automatic add_row(logic md, int cnt, int drw, int fixed, logic [31:0] p, int e);
		stim_row_t r;
		r.mode = md;
		r.cnt = 5'(cnt);
		r.draw = 6'(drw);
		r.fixed = (fixed != 0);
		r.want.prob = PROB_W'(p);
		r.want.err = (e != 0);
		stim_rows.push_back(r);
	endtask

	// offer one item, then record what it should produce once accepted
	task automatic offer(stim_row_t r);
		int gap;
		prob_result_t guess;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.mode;
		s_axis_tdata  <= {5'b0, r.draw, r.cnt};
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
		if (r.mode == MODE_BUILD) begin
			build_occupancy();
			guess = '0;
			build_items++;
		end else begin
			guess = new_draw_prob(r.cnt, r.draw);
			if (guess.err)
				reject_items++;
			else
				query_items++;
		end
		expected_probs.push_back(r.fixed ? r.want : guess);
	endtask

	// stimulus
	initial begin
		stim_row_t r;
		errors = 0;
		sent_items = 0;
		got_items = 0;
		build_items = 0;
		query_items = 0;
		reject_items = 0;
		burst = 1'b0;
		table_ready = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_QUERY;

		// queries on an unbuilt table are rejected, even for the first draw
		add_row(MODE_QUERY, 1, 1, 1, 0, 1);
		add_row(MODE_QUERY, 16, 5, 1, 0, 1);
		add_row(MODE_BUILD, 0, 0, 1, 0, 0);
		// coupon count and draw index out of range
		add_row(MODE_QUERY, 0, 5, 1, 0, 1);
		add_row(MODE_QUERY, 17, 5, 1, 0, 1);
		add_row(MODE_QUERY, 31, 63, 1, 0, 1);
		add_row(MODE_QUERY, 4, 0, 1, 0, 1);
		// first draw is always new
		add_row(MODE_QUERY, 16, 1, 1, Q_ONE, 0);
		add_row(MODE_QUERY, 1, 1, 1, Q_ONE, 0);
		// single coupon gives an empty sum
		add_row(MODE_QUERY, 1, 63, 1, 0, 0);
		add_row(MODE_QUERY, 16, 63, 0, 0, 0);
		add_row(MODE_QUERY, 16, 2, 0, 0, 0);
		add_row(MODE_QUERY, 2, 3, 0, 0, 0);
		add_row(MODE_QUERY, 16, 17, 0, 0, 0);
		add_row(MODE_QUERY, 15, 16, 0, 0, 0);
		// rebuild gives the same table; build ignores its fields
		add_row(MODE_BUILD, 31, 63, 1, 0, 0);
		add_row(MODE_QUERY, 16, 62, 0, 0, 0);
		add_row(MODE_QUERY, 8, 40, 0, 0, 0);
		add_row(MODE_QUERY, 3, 2, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			offer(stim_rows[i]);

		// random queries, mostly in range, some noise
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 100 == 0)
				burst = ($urandom_range(0, 2) == 0);
			r.mode = MODE_QUERY;
			r.fixed = 1'b0;
			r.want = '0;
			if ($urandom_range(0, 9) == 0) begin
				r.cnt = 5'($urandom_range(0, 31));
				r.draw = 6'($urandom_range(0, 63));
			end else begin
				r.cnt = 5'($urandom_range(N_MIN, N_MAX));
				r.draw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, DRAWS - 1))
					: 6'($urandom_range(1, 20));
			end
			offer(r);
		end
		s_axis_tvalid <= 1'b0;

		wait (expected_probs.size() == 0);
		repeat (50) @(posedge clk);
		if (expected_probs.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_probs.size());
			errors++;
		end
		$display("Covered %0d items: %0d builds, %0d in-range queries, %0d rejected queries.",
			sent_items, build_items, query_items, reject_items);
		$display("Received %0d results, including a long output stall.", got_items);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		prob_result_t want;
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 19);
			if (got_items == HOLD_AT)
				stall = HOLD_LEN;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got_items++;
			if (expected_probs.size() == 0) begin
				$display("%0t: unexpected result prob=%h err=%b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = expected_probs.pop_front();
				if (m_axis_tdata !== {1'b0, want.prob}) begin
					$display("%0t: probability expected %h got %h", $time,
						{1'b0, want.prob}, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.err) begin
					$display("%0t: range_error expected %b got %b", $time,
						want.err, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#400_000_000;
		$display("Timeout after %0d of %0d results", got_items, sent_items);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
